// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the averager RTL.
// Every macro samples on clk and is switched off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain clocked property.
`define ACAS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Same-cycle implication.
`define ACAS_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ACAS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/acas_pkg.sv =====
// Shared types and constants of the channel average scaler.
// No dependencies; every RTL module imports this package.
`default_nettype none

package acas_pkg;

    localparam int COUNT_WIDTH = 16;
    localparam int SUM_WIDTH   = 40;
    localparam int NUM_CHAN    = 4;
    localparam int CHAN_W      = 2;
    localparam int CODE_W      = 24;
    localparam int ID_W        = 5;
    localparam int VPC_W       = 32;
    localparam int VREF_W      = 31;
    localparam int AXIS_W      = 32;
    localparam int TEMP_W      = 39;
    localparam int PROD_W      = CODE_W + VPC_W;
    localparam int SCALE_SHIFT = 16;
    localparam int VOLTS_W     = PROD_W - SCALE_SHIFT;
    localparam int TSUM_W      = VOLTS_W + 2;
    localparam int TMUL_W      = TSUM_W + 7;
    localparam int DIV_CNT_W   = $clog2(SUM_WIDTH);
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CHAN_W-1:0] CH_X    = 2'd0;
    localparam logic [CHAN_W-1:0] CH_Y    = 2'd1;
    localparam logic [CHAN_W-1:0] CH_Z    = 2'd2;
    localparam logic [CHAN_W-1:0] CH_TEMP = 2'd3;

    // Largest average magnitudes for a negative and a positive code.
    localparam logic [CODE_W-1:0] MAG_LIMIT_NEG = 24'h800000;
    localparam logic [CODE_W-1:0] MAG_LIMIT_POS = 24'h7fffff;
    // Half a volt in Q.24.
    localparam logic signed [TSUM_W-1:0] HALF_VOLT = 42'sd8388608;

    typedef logic signed [SUM_WIDTH-1:0] sum_t;
    typedef logic [COUNT_WIDTH-1:0]      count_t;
    typedef logic [ID_W-1:0]             chan_id_t;

    typedef struct packed {
        chan_id_t x_id;
        chan_id_t y_id;
        chan_id_t z_id;
        chan_id_t temp_id;
    } chan_ids_t;

    typedef struct packed {
        logic              sample_en;
        chan_id_t          id;
        logic [CODE_W-1:0] code;
        logic              clear_en;
        logic [CHAN_W-1:0] clear_idx;
    } acc_cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_X_ID    = 3'd0,
        REG_Y_ID    = 3'd1,
        REG_Z_ID    = 3'd2,
        REG_TEMP_ID = 3'd3,
        REG_VPC     = 3'd4,
        REG_VREF    = 3'd5
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_MUL,
        ST_SCALE,
        ST_STORE,
        ST_TMUL,
        ST_FIN
    } state_t;

endpackage

`default_nettype wire

// ===== rtl/core/acas_accum.sv =====
// Per-channel sum and count registers with sample routing and clearing.
// Depends on acas_pkg.
`default_nettype none

module acas_accum (
    input  wire                  clk,
    input  wire                  rst_n,
    input  acas_pkg::acc_cmd_t   cmd,
    input  acas_pkg::chan_ids_t  ids,
    output acas_pkg::sum_t       sums   [acas_pkg::NUM_CHAN],
    output acas_pkg::count_t     counts [acas_pkg::NUM_CHAN]
);
    import acas_pkg::*;

    sum_t              sum_reg   [NUM_CHAN];
    count_t            count_reg [NUM_CHAN];
    logic              hit;
    logic [CHAN_W-1:0] sel;
    sum_t              code_ext;
    sum_t              sum_add;
    logic              room;

    // The first matching register wins, in the order X, Y, Z, temperature.
    always_comb
    begin
        hit = 1'b1;
        sel = CH_X;
        if (cmd.id == ids.x_id)
            sel = CH_X;
        else if (cmd.id == ids.y_id)
            sel = CH_Y;
        else if (cmd.id == ids.z_id)
            sel = CH_Z;
        else if (cmd.id == ids.temp_id)
            sel = CH_TEMP;
        else
            hit = 1'b0;
    end

    assign code_ext = {{(SUM_WIDTH-CODE_W){cmd.code[CODE_W-1]}}, cmd.code};
    assign sum_add  = sum_reg[sel] + code_ext;
    assign room     = (count_reg[sel] != '1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_CHAN; k++)
            begin
                sum_reg[k]   <= '0;
                count_reg[k] <= '0;
            end
        end
        else
        begin
            if (cmd.sample_en && hit && room)
            begin
                sum_reg[sel]   <= sum_add;
                count_reg[sel] <= count_reg[sel] + 1'b1;
            end
            if (cmd.clear_en)
            begin
                sum_reg[cmd.clear_idx]   <= '0;
                count_reg[cmd.clear_idx] <= '0;
            end
        end
    end

    always_comb
    begin
        for (int k = 0; k < NUM_CHAN; k++)
        begin
            sums[k]   = sum_reg[k];
            counts[k] = count_reg[k];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/acas_div.sv =====
// Restoring divider, one quotient bit per cycle, for sum magnitude by count.
// Depends on acas_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module acas_div (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              start,
    input  wire [acas_pkg::SUM_WIDTH-1:0]    dividend,
    input  acas_pkg::count_t                 divisor,
    output logic [acas_pkg::SUM_WIDTH-1:0]   quotient,
    output logic                             done,
    output logic                             busy
);
    import acas_pkg::*;

    logic                   busy_reg;
    logic                   done_reg;
    logic [DIV_CNT_W-1:0]   cnt_reg;
    logic [SUM_WIDTH-1:0]   quo_reg;
    logic [SUM_WIDTH-1:0]   quo_next;
    count_t                 rem_reg;
    count_t                 rem_next;
    count_t                 div_reg;
    logic [COUNT_WIDTH:0]   trial;
    logic [COUNT_WIDTH:0]   diff;
    logic                   fits;

    assign trial    = {rem_reg, quo_reg[SUM_WIDTH-1]};
    assign fits     = (trial >= {1'b0, div_reg});
    assign diff     = trial - {1'b0, div_reg};
    assign rem_next = fits ? diff[COUNT_WIDTH-1:0] : trial[COUNT_WIDTH-1:0];
    assign quo_next = {quo_reg[SUM_WIDTH-2:0], fits};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(SUM_WIDTH - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;
    assign busy     = busy_reg;

    `ACAS_ASSERT_IMPL(a_start_when_free, start, !busy_reg, "divider started while busy")
    `ACAS_ASSERT_IMPL(a_done_after_run, done_reg, !busy_reg && $past(busy_reg),
                      "divider done without a finished run")

endmodule

`default_nettype wire

// ===== rtl/core/adc_channel_average_scaler.sv =====
// Per-channel sample averager with fixed-point volt scaling.
// Input channel: in_valid/in_stall with func, chan_word and low_word. A sample
// transaction (func = 0) adds its 24-bit code to the X, Y, Z or temperature
// accumulator whose id matches; the block is ready again in the next cycle.
// A compute transaction (func = 1) averages each channel that holds samples
// through one shared bit-serial divider, one multiplier and a short scaling
// pipeline, and skips each empty channel. in_stall stays high during that
// work. The result transaction then appears on out_valid/out_stall with
// x_volts, y_volts, z_volts, temp_degrees and data_ok, held in an output
// register until the receiver drops out_stall; sample transactions are taken
// meanwhile. A compute transaction that finishes while the previous result
// is still stalled waits for that result to leave.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is
// always high and writes are expected while the block is idle.
// Reset clears all accumulators and last outputs and loads the default ids,
// scale and reference.
// Depends on acas_pkg, acas_accum, acas_div and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module adc_channel_average_scaler (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 in_valid,
    output logic                                in_stall,
    input  wire                                 func,
    input  wire  [15:0]                         chan_word,
    input  wire  [15:0]                         low_word,
    output logic                                out_valid,
    input  wire                                 out_stall,
    output logic signed [acas_pkg::AXIS_W-1:0]  x_volts,
    output logic signed [acas_pkg::AXIS_W-1:0]  y_volts,
    output logic signed [acas_pkg::AXIS_W-1:0]  z_volts,
    output logic signed [acas_pkg::TEMP_W-1:0]  temp_degrees,
    output logic                                data_ok,
    input  wire                                 cfg_valid,
    output logic                                cfg_ready,
    input  wire  [acas_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire  [acas_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import acas_pkg::*;

    // Configuration.
    chan_ids_t          ids_reg;
    logic [VPC_W-1:0]   vpc_reg;
    logic [VREF_W-1:0]  vref_reg;

    // Sequencer.
    state_t             state_reg;
    state_t             state_next;
    logic [CHAN_W-1:0]  chan_reg;
    logic               in_accept;
    logic               chan_has;
    logic               last_chan;
    logic               out_free;

    // Control decoded from the state.
    logic               div_start;
    logic               latch_mag;
    logic               mul_en;
    logic               scale_en;
    logic               store_en;
    logic               tmul_en;
    logic               load_out;
    logic               chan_clr;
    logic               chan_inc;

    // Datapath.
    acc_cmd_t                   acc_cmd;
    sum_t                       sums   [NUM_CHAN];
    count_t                     counts [NUM_CHAN];
    sum_t                       sum_sel;
    logic [SUM_WIDTH-1:0]       sum_mag;
    logic [SUM_WIDTH-1:0]       div_quo;
    logic                       div_done;
    logic                       div_busy;
    logic                       ok_reg;
    logic                       neg_reg;
    logic [CODE_W-1:0]          mag_reg;
    logic [CODE_W-1:0]          mag_clamped;
    logic [PROD_W-1:0]          prod_reg;
    logic [VOLTS_W-1:0]         q_mag;
    logic signed [VOLTS_W-1:0]  volts_reg;
    logic signed [AXIS_W-1:0]   volts_sat;
    logic signed [TSUM_W-1:0]   tsum;
    logic signed [TSUM_W-1:0]   tsum_reg;
    logic signed [TMUL_W-1:0]   tsum_ext;
    logic signed [TMUL_W-1:0]   tmul;
    logic signed [TEMP_W-1:0]   tmul_sat;
    logic signed [AXIS_W-1:0]   last_x_reg;
    logic signed [AXIS_W-1:0]   last_y_reg;
    logic signed [AXIS_W-1:0]   last_z_reg;
    logic signed [TEMP_W-1:0]   last_temp_reg;
    logic                       out_valid_reg;
    logic signed [AXIS_W-1:0]   out_x_reg;
    logic signed [AXIS_W-1:0]   out_y_reg;
    logic signed [AXIS_W-1:0]   out_z_reg;
    logic signed [TEMP_W-1:0]   out_temp_reg;
    logic                       out_ok_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ids_reg.x_id    <= ID_W'(8);
            ids_reg.y_id    <= ID_W'(10);
            ids_reg.z_id    <= ID_W'(12);
            ids_reg.temp_id <= ID_W'(14);
            vpc_reg         <= VPC_W'(349525);
            vref_reg        <= VREF_W'(41943040);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_X_ID:    ids_reg.x_id    <= cfg_data[ID_W-1:0];
                REG_Y_ID:    ids_reg.y_id    <= cfg_data[ID_W-1:0];
                REG_Z_ID:    ids_reg.z_id    <= cfg_data[ID_W-1:0];
                REG_TEMP_ID: ids_reg.temp_id <= cfg_data[ID_W-1:0];
                REG_VPC:     vpc_reg         <= cfg_data[VPC_W-1:0];
                REG_VREF:    vref_reg        <= cfg_data[VREF_W-1:0];
                default:     ;
            endcase
        end
    end

    assign in_accept = in_valid && !in_stall;
    assign chan_has  = (counts[chan_reg] != '0);
    assign last_chan = (chan_reg == CH_TEMP);
    assign out_free  = !out_valid_reg || !out_stall;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && func)
                    state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (chan_has)
                    state_next = ST_DIV;
                else if (last_chan)
                    state_next = ST_FIN;
            end
            ST_DIV:
            begin
                if (div_done)
                    state_next = ST_MUL;
            end
            ST_MUL:   state_next = ST_SCALE;
            ST_SCALE: state_next = ST_STORE;
            ST_STORE: state_next = last_chan ? ST_TMUL : ST_CHECK;
            ST_TMUL:  state_next = ST_FIN;
            ST_FIN:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // Control outputs.
    always_comb
    begin
        in_stall  = 1'b1;
        div_start = 1'b0;
        latch_mag = 1'b0;
        mul_en    = 1'b0;
        scale_en  = 1'b0;
        store_en  = 1'b0;
        tmul_en   = 1'b0;
        load_out  = 1'b0;
        chan_clr  = 1'b0;
        chan_inc  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                chan_clr = 1'b1;
            end
            ST_CHECK:
            begin
                div_start = chan_has;
                chan_inc  = !chan_has && !last_chan;
            end
            ST_DIV:   latch_mag = div_done;
            ST_MUL:   mul_en    = 1'b1;
            ST_SCALE: scale_en  = 1'b1;
            ST_STORE:
            begin
                store_en = 1'b1;
                chan_inc = !last_chan;
            end
            ST_TMUL:  tmul_en  = 1'b1;
            ST_FIN:   load_out = out_free;
            default:  ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            chan_reg  <= CH_X;
            ok_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (chan_clr)
                chan_reg <= CH_X;
            else if (chan_inc)
                chan_reg <= chan_reg + 1'b1;
            if (in_accept && func)
                ok_reg <= (counts[0] != '0) && (counts[1] != '0)
                          && (counts[2] != '0) && (counts[3] != '0);
        end
    end

    always_comb
    begin
        acc_cmd.sample_en = in_accept && !func;
        acc_cmd.id        = chan_word[12:8];
        acc_cmd.code      = {chan_word[7:0], low_word};
        acc_cmd.clear_en  = mul_en;
        acc_cmd.clear_idx = chan_reg;
    end

    acas_accum u_accum (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (acc_cmd),
        .ids    (ids_reg),
        .sums   (sums),
        .counts (counts)
    );

    assign sum_sel = sums[chan_reg];
    assign sum_mag = sum_sel[SUM_WIDTH-1] ? SUM_WIDTH'(-sum_sel) : SUM_WIDTH'(sum_sel);

    acas_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_mag),
        .divisor  (counts[chan_reg]),
        .quotient (div_quo),
        .done     (div_done),
        .busy     (div_busy)
    );

    // An average that left the code range is clamped.
    always_comb
    begin
        if (sum_sel[SUM_WIDTH-1])
            mag_clamped = (div_quo > SUM_WIDTH'(MAG_LIMIT_NEG)) ? MAG_LIMIT_NEG
                                                                : div_quo[CODE_W-1:0];
        else
            mag_clamped = (div_quo > SUM_WIDTH'(MAG_LIMIT_POS)) ? MAG_LIMIT_POS
                                                                : div_quo[CODE_W-1:0];
    end

    assign q_mag = prod_reg[PROD_W-1:SCALE_SHIFT];

    always_comb
    begin
        if (volts_reg > VOLTS_W'(signed'({1'b0, {(AXIS_W-1){1'b1}}})))
            volts_sat = {1'b0, {(AXIS_W-1){1'b1}}};
        else if (volts_reg < -VOLTS_W'(signed'({1'b0, 1'b1, {(AXIS_W-1){1'b0}}})))
            volts_sat = {1'b1, {(AXIS_W-1){1'b0}}};
        else
            volts_sat = volts_reg[AXIS_W-1:0];
    end

    assign tsum = TSUM_W'(volts_reg) + signed'(TSUM_W'(vref_reg)) - HALF_VOLT;

    // Times 100 as 64 + 32 + 4.
    assign tsum_ext = TMUL_W'(tsum_reg);
    assign tmul     = (tsum_ext <<< 6) + (tsum_ext <<< 5) + (tsum_ext <<< 2);

    always_comb
    begin
        if (tmul > TMUL_W'(signed'({1'b0, {(TEMP_W-1){1'b1}}})))
            tmul_sat = {1'b0, {(TEMP_W-1){1'b1}}};
        else if (tmul < -TMUL_W'(signed'({1'b0, 1'b1, {(TEMP_W-1){1'b0}}})))
            tmul_sat = {1'b1, {(TEMP_W-1){1'b0}}};
        else
            tmul_sat = tmul[TEMP_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (latch_mag)
        begin
            mag_reg <= mag_clamped;
            neg_reg <= sum_sel[SUM_WIDTH-1];
        end
        if (mul_en)
            prod_reg <= PROD_W'(mag_reg) * PROD_W'(vpc_reg);
        if (scale_en)
            volts_reg <= neg_reg ? -signed'(q_mag) : signed'(q_mag);
        if (store_en && last_chan)
            tsum_reg <= tsum;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_x_reg    <= '0;
            last_y_reg    <= '0;
            last_z_reg    <= '0;
            last_temp_reg <= '0;
        end
        else
        begin
            if (store_en)
            begin
                case (chan_reg)
                    CH_X:    last_x_reg <= volts_sat;
                    CH_Y:    last_y_reg <= volts_sat;
                    CH_Z:    last_z_reg <= volts_sat;
                    default: ;
                endcase
            end
            if (tmul_en)
                last_temp_reg <= tmul_sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load_out)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_x_reg    <= last_x_reg;
            out_y_reg    <= last_y_reg;
            out_z_reg    <= last_z_reg;
            out_temp_reg <= last_temp_reg;
            out_ok_reg   <= ok_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign x_volts      = out_x_reg;
    assign y_volts      = out_y_reg;
    assign z_volts      = out_z_reg;
    assign temp_degrees = out_temp_reg;
    assign data_ok      = out_ok_reg;

    `ACAS_ASSERT_IMPL(a_div_done_in_div, div_done, state_reg == ST_DIV,
                      "divider finished outside the divide state")
    `ACAS_ASSERT_IMPL(a_div_idle_at_check, state_reg == ST_CHECK, !div_busy,
                      "divider still running when a channel is checked")
    `ACAS_ASSERT_IMPL(a_result_from_fin, $rose(out_valid_reg), $past(state_reg) == ST_FIN,
                      "result raised outside the finish state")
    `ACAS_ASSERT_NEXT(a_compute_starts, in_accept && func, state_reg == ST_CHECK,
                      "compute transaction did not start the sequence")

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
// Self-checking testbench for the channel average scaler: sample and compute
// transactions with random pacing, every report compared with a local model or a typed report.
// Depends on acas_pkg and the adc_channel_average_scaler RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import acas_pkg::*;

    localparam logic OP_SAMPLE  = 1'b0;
    localparam logic OP_COMPUTE = 1'b1;
    // Indexes past the last register; writes to them must be ignored.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    localparam int     SETTLE_CYCLES      = 8;
    localparam int     WATCHDOG_LIMIT     = 3000;
    localparam int     RANDOM_PER_SETTING = 105;
    localparam int     NUM_SETTINGS       = 7;
    localparam longint DEGREES_PER_VOLT   = 100;

    typedef struct packed {
        logic signed [AXIS_W-1:0] x;
        logic signed [AXIS_W-1:0] y;
        logic signed [AXIS_W-1:0] z;
        logic signed [TEMP_W-1:0] temp;
        logic                     ok;
    } volt_report_t;

    typedef struct packed {
        logic                     op;
        logic [15:0]              cw;
        logic [15:0]              lw;
        logic                     typed;
        logic signed [AXIS_W-1:0] x;
        logic signed [AXIS_W-1:0] y;
        logic signed [AXIS_W-1:0] z;
        logic signed [TEMP_W-1:0] temp;
        logic                     ok;
    } probe_t;

    // Directed rows; a typed report is used instead of the model's where set.
    localparam probe_t DIRECTED [26] = '{
        '{OP_COMPUTE, 16'hffff, 16'hffff, 1'b1, 0, 0, 0, 0, 1'b0},
        '{OP_SAMPLE,  16'h0800, 16'h0000, 1'b0, 0, 0, 0, 0, 1'b0},
        '{OP_SAMPLE,  16'h0a00, 16'h0000, 1'b0, 0, 0, 0, 0, 1'b0},
        '{OP_SAMPLE,  16'h0c00, 16'h0000, 1'b0, 0, 0, 0, 0, 1'b0},
        '{OP_SAMPLE,  16'h0e00, 16'h0000, 1'b0, 0, 0, 0, 0, 1'b0},
        '{OP_COMPUTE, 16'h0000, 16'h0000, 1'b1, 0, 0, 0, 39'sd3355443200, 1'b1},
        '{OP_SAMPLE,  16'h087f, 16'hffff, 1'b0, 0, 0, 0, 0, 1'b0},
        '{OP_SAMPLE,  16'h0a80, 16'h0000, 1'b0, 0, 0, 0, 0, 1'b0},
        '{OP_SAMPLE,  16'h0cff, 16'hffff, 1'b0, 0, 0, 0, 0, 1'b0},
        '{OP_SAMPLE,  16'h0e7f, 16'hffff, 1'b0, 0, 0, 0, 0, 1'b0},
        '{OP_SAMPLE,  16'hffff, 16'hffff, 1'b0, 0, 0, 0, 0, 1'b0},
        '{OP_SAMPLE,  16'h0900, 16'h5555, 1'b0, 0, 0, 0, 0, 1'b0},
        '{OP_COMPUTE, 16'h1234, 16'habcd, 1'b0, 0, 0, 0, 0, 1'b0},
        '{OP_COMPUTE, 16'h0000, 16'h0000, 1'b0, 0, 0, 0, 0, 1'b0},
        '{OP_SAMPLE,  16'h0880, 16'h0000, 1'b0, 0, 0, 0, 0, 1'b0},
        '{OP_SAMPLE,  16'h0880, 16'h0001, 1'b0, 0, 0, 0, 0, 1'b0},
        '{OP_SAMPLE,  16'h087f, 16'hffff, 1'b0, 0, 0, 0, 0, 1'b0},
        '{OP_SAMPLE,  16'he87f, 16'hffff, 1'b0, 0, 0, 0, 0, 1'b0},
        '{OP_COMPUTE, 16'hffff, 16'h0000, 1'b0, 0, 0, 0, 0, 1'b0},
        '{OP_SAMPLE,  16'h0a12, 16'h3456, 1'b0, 0, 0, 0, 0, 1'b0},
        '{OP_SAMPLE,  16'h0a00, 16'h0001, 1'b0, 0, 0, 0, 0, 1'b0},
        '{OP_SAMPLE,  16'h0cff, 16'hfffe, 1'b0, 0, 0, 0, 0, 1'b0},
        '{OP_SAMPLE,  16'h0c00, 16'h0001, 1'b0, 0, 0, 0, 0, 1'b0},
        '{OP_SAMPLE,  16'h0eff, 16'hfffd, 1'b0, 0, 0, 0, 0, 1'b0},
        '{OP_SAMPLE,  16'h0e00, 16'h0001, 1'b0, 0, 0, 0, 0, 1'b0},
        '{OP_COMPUTE, 16'h0000, 16'hffff, 1'b0, 0, 0, 0, 0, 1'b0}
    };

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_stall;
    logic                     func = 1'b0;
    logic [15:0]              chan_word = '0;
    logic [15:0]              low_word = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic signed [AXIS_W-1:0] x_volts;
    logic signed [AXIS_W-1:0] y_volts;
    logic signed [AXIS_W-1:0] z_volts;
    logic signed [TEMP_W-1:0] temp_degrees;
    logic                     data_ok;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CFG_IDX_W-1:0]     cfg_index = '0;
    logic [CFG_DATA_W-1:0]    cfg_data = '0;

    adc_channel_average_scaler uut (.*);

    always #10 clk = ~clk;

    // Model state: configuration, accumulators and the last reported values.
    chan_id_t                 chan_ids [NUM_CHAN];
    logic [VPC_W-1:0]         volts_scale;
    logic [VREF_W-1:0]        vref_q24;
    sum_t                     acc_sum [NUM_CHAN];
    count_t                   acc_count [NUM_CHAN];
    logic signed [AXIS_W-1:0] held_axis [3];
    logic signed [TEMP_W-1:0] held_temp;

    volt_report_t pending_reports [$];
    volt_report_t arrived_want;

    int  error_count = 0;
    int  reports_checked = 0;
    int  samples_sent = 0;
    int  computes_sent = 0;
    int  reg_writes = 0;
    int  burst_left = 0;
    bit  pacing_on = 1'b1;
    int  stall_pct = 0;
    int  pattern_left = 0;
    int  quiet_cycles = 0;

    function automatic longint saturate(longint v, int w);
        longint hi;
        longint lo;
        hi = (64'sd1 <<< (w - 1)) - 1;
        lo = -hi - 1;
        return (v > hi) ? hi : ((v < lo) ? lo : v);
    endfunction

    // Average of one accumulator in Q.24 volts, before saturation; clears it.
    function automatic longint drain_channel(int k);
        longint          avg;
        longint          cnt;
        longint          q;
        longint unsigned mag;
        logic            neg;
        avg = acc_sum[k];
        cnt = acc_count[k];
        avg = avg / cnt;
        if (avg > longint'(MAG_LIMIT_POS))
            avg = longint'(MAG_LIMIT_POS);
        if (avg < -longint'(MAG_LIMIT_NEG))
            avg = -longint'(MAG_LIMIT_NEG);
        neg = (avg < 0);
        mag = neg ? -avg : avg;
        q = (mag * volts_scale) >> SCALE_SHIFT;
        acc_sum[k] = '0;
        acc_count[k] = '0;
        return neg ? -q : q;
    endfunction

    function automatic void absorb_sample(logic [15:0] cw, logic [15:0] lw);
        logic signed [CODE_W-1:0] code;
        int                       sel;
        code = {cw[7:0], lw};
        sel = -1;
        // Walk backwards so that the first matching accumulator wins.
        for (int k = NUM_CHAN - 1; k >= 0; k--)
            if (chan_ids[k] == cw[12:8])
                sel = k;
        if (sel >= 0 && acc_count[sel] != '1)
        begin
            acc_sum[sel] = acc_sum[sel] + code;
            acc_count[sel] = acc_count[sel] + 1'b1;
        end
    endfunction

    function automatic volt_report_t compute_report();
        volt_report_t r;
        longint       v;
        longint       vref_l;
        longint       half_l;
        r.ok = 1'b1;
        for (int k = 0; k < 3; k++)
        begin
            if (acc_count[k] != 0)
                held_axis[k] = saturate(drain_channel(k), AXIS_W);
            else
                r.ok = 1'b0;
        end
        if (acc_count[CH_TEMP] != 0)
        begin
            v = drain_channel(CH_TEMP);
            vref_l = vref_q24;
            half_l = HALF_VOLT;
            held_temp = saturate((v + vref_l - half_l) * DEGREES_PER_VOLT, TEMP_W);
        end
        else
            r.ok = 1'b0;
        r.x = held_axis[CH_X];
        r.y = held_axis[CH_Y];
        r.z = held_axis[CH_Z];
        r.temp = held_temp;
        return r;
    endfunction

    task automatic send_item(logic op, logic [15:0] cw, logic [15:0] lw,
                             logic typed = 1'b0, volt_report_t want = '0);
        volt_report_t predicted;
        in_valid <= 1'b1;
        func <= op;
        chan_word <= cw;
        low_word <= lw;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (op == OP_COMPUTE)
        begin
            predicted = compute_report();
            pending_reports.push_back(typed ? want : predicted);
            computes_sent++;
        end
        else
        begin
            absorb_sample(cw, lw);
            samples_sent++;
        end
        if (pacing_on)
        begin
            if (burst_left == 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 15))
                    @(posedge clk);
                burst_left = $urandom_range(1, 24);
            end
            else
                burst_left--;
        end
    endtask

    // Leaves cfg_valid high; the caller lowers it after the last write.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_X_ID:    chan_ids[CH_X] = data[ID_W-1:0];
            REG_Y_ID:    chan_ids[CH_Y] = data[ID_W-1:0];
            REG_Z_ID:    chan_ids[CH_Z] = data[ID_W-1:0];
            REG_TEMP_ID: chan_ids[CH_TEMP] = data[ID_W-1:0];
            REG_VPC:     volts_scale = data;
            REG_VREF:    vref_q24 = data[VREF_W-1:0];
            default:     ;
        endcase
        reg_writes++;
    endtask

    // Unused upper bits carry random junk to check that the block masks them.
    task automatic apply_setting(chan_id_t xid, chan_id_t yid, chan_id_t zid, chan_id_t tid,
                                 logic [VPC_W-1:0] vpc, logic [VREF_W-1:0] vref);
        write_reg(REG_X_ID, ($urandom() & ~32'h1f) | xid);
        write_reg(REG_Y_ID, ($urandom() & ~32'h1f) | yid);
        write_reg(REG_Z_ID, ($urandom() & ~32'h1f) | zid);
        write_reg(REG_TEMP_ID, ($urandom() & ~32'h1f) | tid);
        write_reg(REG_VPC, vpc);
        write_reg(REG_VREF, ($urandom() & 32'h8000_0000) | vref);
        write_reg(REG_SPARE_LO, $urandom());
        write_reg(REG_SPARE_HI, $urandom());
        cfg_valid <= 1'b0;
    endtask

    task automatic drain_and_settle();
        in_valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    // Mostly well-formed samples to the configured channels, some noise and compute requests.
    task automatic random_traffic(int n);
        int                useful;
        int                roll;
        int                ch;
        logic [CODE_W-1:0] code;
        logic [2:0]        top;
        useful = 0;
        pacing_on = ($urandom_range(0, 3) != 0);
        while (useful < n)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 9)
            begin
                send_item(OP_COMPUTE, 16'($urandom()), 16'($urandom()));
                useful++;
            end
            else if (roll < 19)
                send_item(OP_SAMPLE, 16'($urandom()), 16'($urandom()));
            else
            begin
                case ($urandom_range(0, 3))
                    0:       code = MAG_LIMIT_POS;
                    1:       code = MAG_LIMIT_NEG;
                    2:       code = CODE_W'($urandom_range(0, 511)) - 24'd256;
                    default: code = CODE_W'($urandom());
                endcase
                ch = $urandom_range(0, NUM_CHAN - 1);
                top = 3'($urandom());
                send_item(OP_SAMPLE, {top, chan_ids[ch], code[23:16]}, code[15:0]);
                useful++;
            end
        end
    endtask

    task automatic check_field(string name, longint want, longint got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            error_count++;
        end
    endtask

    // Report checker and receiver stall pattern.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_reports.size() == 0)
            begin
                $display("%0t: report with nothing expected, actual x %0d y %0d z %0d temp %0d ok %0d",
                         $time, x_volts, y_volts, z_volts, temp_degrees, data_ok);
                error_count++;
            end
            else
            begin
                arrived_want = pending_reports.pop_front();
                check_field("x_volts", arrived_want.x, x_volts);
                check_field("y_volts", arrived_want.y, y_volts);
                check_field("z_volts", arrived_want.z, z_volts);
                check_field("temp_degrees", arrived_want.temp, temp_degrees);
                check_field("data_ok", arrived_want.ok, data_ok);
                reports_checked++;
            end
        end
        if (pattern_left == 0)
        begin
            case ($urandom_range(0, 2))
                0:       stall_pct = 0;
                1:       stall_pct = 30;
                default: stall_pct = 80;
            endcase
            pattern_left = $urandom_range(32, 256);
        end
        else
            pattern_left--;
        out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("Verification failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        volt_report_t want;
        chan_ids[CH_X] = 5'd8;
        chan_ids[CH_Y] = 5'd10;
        chan_ids[CH_Z] = 5'd12;
        chan_ids[CH_TEMP] = 5'd14;
        volts_scale = 32'd349525;
        vref_q24 = 31'd41943040;
        foreach (acc_sum[k])
        begin
            acc_sum[k] = '0;
            acc_count[k] = '0;
        end
        foreach (held_axis[k])
            held_axis[k] = '0;
        held_temp = '0;

        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED[i])
        begin
            want.x = DIRECTED[i].x;
            want.y = DIRECTED[i].y;
            want.z = DIRECTED[i].z;
            want.temp = DIRECTED[i].temp;
            want.ok = DIRECTED[i].ok;
            send_item(DIRECTED[i].op, DIRECTED[i].cw, DIRECTED[i].lw, DIRECTED[i].typed, want);
        end
        drain_and_settle();

        for (int s = 0; s < NUM_SETTINGS; s++)
        begin
            case (s)
                0: apply_setting(5'd8, 5'd10, 5'd12, 5'd14, 32'd349525, 31'd41943040);
                1: apply_setting(5'd0, 5'd31, 5'd1, 5'd30, 32'hffff_ffff, 31'h7fff_ffff);
                2: apply_setting(5'd0, 5'd0, 5'd0, 5'd0, 32'd0, 31'd0);
                3: apply_setting(5'd5, 5'd5, 5'd6, 5'd6, $urandom(), 31'($urandom()));
                6: apply_setting(5'd31, 5'd30, 5'd29, 5'd0, 32'd1, 31'h7fff_ffff);
                default: apply_setting(5'($urandom()), 5'($urandom()), 5'($urandom()),
                                       5'($urandom()), $urandom(), 31'($urandom()));
            endcase
            random_traffic(RANDOM_PER_SETTING);
            drain_and_settle();
        end

        $display("Sent %0d samples and %0d compute requests across %0d register writes.",
                 samples_sent, computes_sent, reg_writes);
        $display("Compared %0d reports, %0d mismatches.", reports_checked, error_count);
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/acas_pkg.sv
rtl/core/acas_accum.sv
rtl/core/acas_div.sv
rtl/core/adc_channel_average_scaler.sv
bench/tb.sv
